### hdl/tbar_pkg.sv
// Shared types, constants and arithmetic helpers for the two-background alpha recovery block.
package tbar_pkg;

  localparam int unsigned ChanW         = 8;
  localparam int unsigned NumChan       = 3;
  localparam int unsigned DivSteps      = ChanW;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages     = DivSteps / StepsPerStage;

  localparam logic [ChanW-1:0] FullScale   = 8'd255;
  localparam logic [ChanW-1:0] CutoffReset = 8'd8;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t [NumChan-1:0] black;
    chan_t               alpha;
    logic                clear;
  } alpha_t;

  typedef struct packed {
    chan_t rem;
    chan_t word;
    logic  sat;
  } lane_t;

  typedef struct packed {
    lane_t [NumChan-1:0] lane;
    chan_t               alpha;
    logic                clear;
  } quo_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
    chan_t alpha;
  } pix_t;

  function automatic chan_t abs_diff(chan_t a, chan_t b);
    chan_t r;
    if (a > b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

  // one restoring division step: shift in next numerator bit, subtract if it fits
  function automatic lane_t div_step(lane_t l, chan_t d);
    logic [ChanW:0] trial;
    logic [ChanW:0] diff;
    lane_t          r;
    trial = {l.rem, l.word[ChanW-1]};
    diff  = trial - {1'b0, d};
    r     = l;
    if (trial >= {1'b0, d}) begin
      r.rem  = diff[ChanW-1:0];
      r.word = {l.word[ChanW-2:0], 1'b1};
    end else begin
      r.rem  = trial[ChanW-1:0];
      r.word = {l.word[ChanW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### hdl/tbar_if.sv
// Channel interfaces for pixel input, pixel output and the cutoff register write.
interface tbar_in_if;
  logic               valid;
  logic               ready;
  tbar_pkg::chan_t    black_blue;
  tbar_pkg::chan_t    black_green;
  tbar_pkg::chan_t    black_red;
  tbar_pkg::chan_t    white_blue;
  tbar_pkg::chan_t    white_green;
  tbar_pkg::chan_t    white_red;

  modport source (output valid, output black_blue, output black_green, output black_red,
                  output white_blue, output white_green, output white_red, input ready);
  modport sink   (input valid, input black_blue, input black_green, input black_red,
                  input white_blue, input white_green, input white_red, output ready);
endinterface

interface tbar_out_if;
  logic               valid;
  logic               ready;
  tbar_pkg::chan_t    out_blue;
  tbar_pkg::chan_t    out_green;
  tbar_pkg::chan_t    out_red;
  tbar_pkg::chan_t    out_alpha;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output out_alpha, input ready);
  modport sink   (input valid, input out_blue, input out_green, input out_red,
                  input out_alpha, output ready);
endinterface

interface tbar_cfg_if;
  logic               valid;
  logic               ready;
  tbar_pkg::chan_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/two_background_alpha_recover_invert.sv
// Top level of the two-background alpha recovery and color inversion pipeline.
// One pixel item enters per clock while no stall holds it back, and its result
// passes through one opacity stage, one numerator stage, four division stages
// that each retire two quotient bits of all three channels, and the output
// register. Every stage holds its item under back-pressure and fills bubbles, so
// a stalled output does not stop items from moving up behind it. The cutoff
// register resets to 8 and is sampled as an item enters, so write it while idle.
module two_background_alpha_recover_invert (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbar_in_if.sink     in_i,
  tbar_out_if.source  out_o,
  tbar_cfg_if.sink    cfg_i
);

  tbar_pkg::chan_t         cutoff_q;
  tbar_pkg::chan_t [5:0]   pix;
  logic                    a_valid, a_ready;
  tbar_pkg::alpha_t        a_data;
  logic                    q_valid, q_ready;
  tbar_pkg::quo_t          q_data;
  tbar_pkg::pix_t          o_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= tbar_pkg::CutoffReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      cutoff_q <= cfg_i.data;
    end
  end

  assign pix = {in_i.white_red, in_i.white_green, in_i.white_blue,
                in_i.black_red, in_i.black_green, in_i.black_blue};

  tbar_alpha u_alpha (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cutoff_i (cutoff_q),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .pix_i    (pix),
    .valid_o  (a_valid),
    .ready_i  (a_ready),
    .data_o   (a_data)
  );

  tbar_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_valid),
    .ready_o (a_ready),
    .data_i  (a_data),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .data_o  (q_data)
  );

  tbar_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ready_o (q_ready),
    .data_i  (q_data),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (o_data)
  );

  assign out_o.out_blue  = o_data.blue;
  assign out_o.out_green = o_data.green;
  assign out_o.out_red   = o_data.red;
  assign out_o.out_alpha = o_data.alpha;

  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> a_valid)
    else $error("accepted item did not reach the opacity stage");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid && !a_ready |=> a_valid && $stable(a_data))
    else $error("opacity stage lost or changed a stalled item");

  a_zero_alpha_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.out_alpha == '0 |->
      out_o.out_blue == '0 && out_o.out_green == '0 && out_o.out_red == '0)
    else $error("transparent item carries color");

endmodule

### hdl/tbar_alpha.sv
// First stage: channel differences, opacity recovery and transparency decision.
module tbar_alpha (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tbar_pkg::chan_t         cutoff_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  tbar_pkg::chan_t [5:0]   pix_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output tbar_pkg::alpha_t        data_o
);

  logic             valid_q;
  tbar_pkg::alpha_t data_q, data_d;
  tbar_pkg::chan_t  diff_b, diff_g, diff_r, diff_max;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    diff_b   = tbar_pkg::abs_diff(pix_i[3], pix_i[0]);
    diff_g   = tbar_pkg::abs_diff(pix_i[4], pix_i[1]);
    diff_r   = tbar_pkg::abs_diff(pix_i[5], pix_i[2]);
    diff_max = diff_b;
    if (diff_g > diff_max) begin
      diff_max = diff_g;
    end
    if (diff_r > diff_max) begin
      diff_max = diff_r;
    end
    data_d.black = pix_i[2:0];
    data_d.alpha = tbar_pkg::FullScale - diff_max;
    data_d.clear = data_d.alpha <= cutoff_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hdl/tbar_div.sv
// Numerator setup and pipelined restoring division of the three channels by opacity.
module tbar_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  tbar_pkg::alpha_t  data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output tbar_pkg::quo_t    data_o
);

  localparam int unsigned NStg = tbar_pkg::DivStages + 1;

  logic           valid_q [NStg];
  logic           rdy     [NStg+1];
  logic           vin     [NStg];
  tbar_pkg::quo_t data_q  [NStg];
  tbar_pkg::quo_t data_d  [NStg];
  tbar_pkg::quo_t init_d;

  always_comb begin
    logic [2*tbar_pkg::ChanW-1:0] num;
    init_d.alpha = data_i.alpha;
    init_d.clear = data_i.clear;
    for (int c = 0; c < tbar_pkg::NumChan; c++) begin
      num = {data_i.black[c], {tbar_pkg::ChanW{1'b0}}}
            - {{tbar_pkg::ChanW{1'b0}}, data_i.black[c]}
            + {{(tbar_pkg::ChanW+1){1'b0}}, data_i.alpha[tbar_pkg::ChanW-1:1]};
      init_d.lane[c].rem  = num[2*tbar_pkg::ChanW-1:tbar_pkg::ChanW];
      init_d.lane[c].word = num[tbar_pkg::ChanW-1:0];
      init_d.lane[c].sat  = num[2*tbar_pkg::ChanW-1:tbar_pkg::ChanW] >= data_i.alpha;
    end
  end

  assign rdy[NStg] = ready_i;
  assign ready_o   = rdy[0];

  for (genvar s = 0; s < NStg; s++) begin : g_stage
    assign rdy[s] = !valid_q[s] || rdy[s+1];

    if (s == 0) begin : g_init
      assign vin[s]    = valid_i;
      assign data_d[s] = init_d;
    end else begin : g_step
      assign vin[s] = valid_q[s-1];
      always_comb begin
        data_d[s] = data_q[s-1];
        for (int c = 0; c < tbar_pkg::NumChan; c++) begin
          for (int k = 0; k < tbar_pkg::StepsPerStage; k++) begin
            data_d[s].lane[c] = tbar_pkg::div_step(data_d[s].lane[c], data_q[s-1].alpha);
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid_q[s] <= vin[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && vin[s]) begin
        data_q[s] <= data_d[s];
      end
    end
  end

  assign valid_o = valid_q[NStg-1];
  assign data_o  = data_q[NStg-1];

endmodule

### hdl/tbar_out.sv
// Output stage: saturate, invert and zero transparent pixels into the output register.
module tbar_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  tbar_pkg::quo_t    data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output tbar_pkg::pix_t    data_o
);

  logic                               valid_q;
  tbar_pkg::pix_t                     data_q, data_d;
  tbar_pkg::chan_t [tbar_pkg::NumChan-1:0] col;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    for (int c = 0; c < tbar_pkg::NumChan; c++) begin
      if (data_i.clear || data_i.lane[c].sat) begin
        col[c] = '0;
      end else begin
        col[c] = tbar_pkg::FullScale - data_i.lane[c].word;
      end
    end
    data_d.blue  = col[0];
    data_d.green = col[1];
    data_d.red   = col[2];
    data_d.alpha = data_i.clear ? '0 : data_i.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### test/tbar_checker.sv
// Checker for the alpha recovery block: tracks the cutoff, predicts each pixel, compares results.
`timescale 1ns / 100ps
module tbar_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tbar_in_if   in_i,
  tbar_out_if  out_i,
  tbar_cfg_if  cfg_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);

  localparam int MaxReports = 10;

  tbar_pkg::chan_t cutoff;
  tbar_pkg::pix_t  expected_pixels [$];

  function automatic int chan_gap(tbar_pkg::chan_t a, tbar_pkg::chan_t b);
    int diff;
    diff = int'(a) - int'(b);
    return (diff < 0) ? -diff : diff;
  endfunction

  function automatic tbar_pkg::chan_t invert_channel(tbar_pkg::chan_t c, int alpha);
    int level;
    level = (int'(c) * int'(tbar_pkg::FullScale) + alpha / 2) / alpha;
    if (level > int'(tbar_pkg::FullScale)) begin
      level = int'(tbar_pkg::FullScale);
    end
    return tbar_pkg::chan_t'(int'(tbar_pkg::FullScale) - level);
  endfunction

  function automatic tbar_pkg::pix_t recover_pixel(
    tbar_pkg::chan_t bb, tbar_pkg::chan_t bg, tbar_pkg::chan_t br,
    tbar_pkg::chan_t wb, tbar_pkg::chan_t wg, tbar_pkg::chan_t wr,
    tbar_pkg::chan_t limit);
    int             spread;
    int             alpha;
    tbar_pkg::pix_t px;
    spread = chan_gap(wb, bb);
    if (chan_gap(wg, bg) > spread) begin
      spread = chan_gap(wg, bg);
    end
    if (chan_gap(wr, br) > spread) begin
      spread = chan_gap(wr, br);
    end
    alpha = int'(tbar_pkg::FullScale) - spread;
    px    = '0;
    if (alpha > int'(limit)) begin
      px.blue  = invert_channel(bb, alpha);
      px.green = invert_channel(bg, alpha);
      px.red   = invert_channel(br, alpha);
      px.alpha = tbar_pkg::chan_t'(alpha);
    end
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tbar_pkg::pix_t got;
    tbar_pkg::pix_t want;
    if (!rst_ni) begin
      cutoff       <= tbar_pkg::CutoffReset;
      expected_pixels.delete();
      fail_count_o <= 0;
      checked_o    <= 0;
      pending_o    <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        got.blue  = out_i.out_blue;
        got.green = out_i.out_green;
        got.red   = out_i.out_red;
        got.alpha = out_i.out_alpha;
        checked_o <= checked_o + 1;
        if (expected_pixels.size() == 0) begin
          if (fail_count_o < MaxReports) begin
            $display("%0t: unexpected item b=%0d g=%0d r=%0d a=%0d", $realtime,
                     got.blue, got.green, got.red, got.alpha);
          end
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (want != got) begin
            if (fail_count_o < MaxReports) begin
              $display({"%0t: mismatch expected b=%0d g=%0d r=%0d a=%0d,",
                        " got b=%0d g=%0d r=%0d a=%0d"},
                       $realtime, want.blue, want.green, want.red, want.alpha,
                       got.blue, got.green, got.red, got.alpha);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        expected_pixels.push_back(recover_pixel(in_i.black_blue, in_i.black_green,
                                                in_i.black_red, in_i.white_blue,
                                                in_i.white_green, in_i.white_red, cutoff));
      end
      if (cfg_i.valid && cfg_i.ready) begin
        cutoff <= cfg_i.data;
      end
      pending_o <= expected_pixels.size();
    end
  end

endmodule

### test/tb_two_background_alpha_recover_invert.sv
// Testbench top for the alpha recovery block: clock, reset, pixel and cutoff stimulus, verdict.
`timescale 1ns / 100ps
module tb_two_background_alpha_recover_invert;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 12;
  localparam int ItemsPerPhase = 250;
  localparam int NumPhases     = 8;
  localparam int DrainCycles   = 20;
  localparam int CycleLimit    = 400000;

  typedef enum int {NoIdle, SenderIdle, ReceiverStall, BothIdle} idle_mode_e;

  logic            clk;
  logic            rst_n;
  int              sender_idle_pct    = 0;
  int              receiver_stall_pct = 0;
  int              fail_count;
  int              pending;
  int              checked;
  int              sent = 0;
  tbar_pkg::chan_t cutoff_now = tbar_pkg::CutoffReset;

  tbar_in_if  in_bus ();
  tbar_out_if out_bus ();
  tbar_cfg_if cfg_bus ();

  two_background_alpha_recover_invert u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  tbar_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_bus),
    .out_i        (out_bus),
    .cfg_i        (cfg_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    out_bus.ready = 1'b1;
    forever begin
      @(negedge clk);
      out_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic set_idle_mode(idle_mode_e mode);
    case (mode)
      NoIdle: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      SenderIdle: begin
        sender_idle_pct    = 74;
        receiver_stall_pct = 0;
      end
      ReceiverStall: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 74;
      end
      default: begin
        sender_idle_pct    = 7;
        receiver_stall_pct = 7;
      end
    endcase
  endtask

  // index 0 blue, 1 green, 2 red
  task automatic send_pixel(tbar_pkg::chan_t [2:0] blk, tbar_pkg::chan_t [2:0] wht);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.black_blue  <= blk[0];
    in_bus.black_green <= blk[1];
    in_bus.black_red   <= blk[2];
    in_bus.white_blue  <= wht[0];
    in_bus.white_green <= wht[1];
    in_bus.white_red   <= wht[2];
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_pixels();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_cutoff(tbar_pkg::chan_t value);
    drain_pixels();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    cutoff_now = value;
  endtask

  // bias most pixels toward a chosen opacity, often right around the cutoff
  task automatic send_random_pixel();
    tbar_pkg::chan_t [2:0] blk;
    tbar_pkg::chan_t [2:0] wht;
    int                    alpha;
    int                    spread;
    int                    lead;
    int                    delta;
    int                    low;
    int                    ch;
    if ($urandom_range(99) < 40) begin
      blk = 24'($urandom);
      wht = 24'($urandom);
    end else begin
      case ($urandom_range(3))
        0:       alpha = int'(cutoff_now) + $urandom_range(3) - 1;
        1:       alpha = $urandom_range(255);
        2:       alpha = $urandom_range(255, 200);
        default: alpha = $urandom_range(16, 1);
      endcase
      if (alpha < 0) begin
        alpha = 0;
      end
      if (alpha > 255) begin
        alpha = 255;
      end
      spread = 255 - alpha;
      lead   = $urandom_range(2);
      for (ch = 0; ch < 3; ch++) begin
        delta = (ch == lead) ? spread : $urandom_range(spread);
        low   = $urandom_range(255 - delta);
        if ($urandom_range(1) == 1) begin
          blk[ch] = tbar_pkg::chan_t'(low);
          wht[ch] = tbar_pkg::chan_t'(low + delta);
        end else begin
          wht[ch] = tbar_pkg::chan_t'(low);
          blk[ch] = tbar_pkg::chan_t'(low + delta);
        end
      end
    end
    send_pixel(blk, wht);
  endtask

  initial begin
    tbar_pkg::chan_t cutoff_plan [NumPhases];
    int              p;
    int              n;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.black_blue  = '0;
    in_bus.black_green = '0;
    in_bus.black_red   = '0;
    in_bus.white_blue  = '0;
    in_bus.white_green = '0;
    in_bus.white_red   = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.data       = '0;
    cutoff_plan = '{8'd0, 8'd255, 8'd8, 8'd1, 8'd254, 8'd128, 8'd0, 8'd0};
    cutoff_plan[6] = tbar_pkg::chan_t'($urandom);
    cutoff_plan[7] = tbar_pkg::chan_t'($urandom);
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    set_idle_mode(NoIdle);
    send_pixel({8'd0, 8'd0, 8'd0}, {8'd0, 8'd0, 8'd0});
    send_pixel({8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255});
    send_pixel({8'd255, 8'd255, 8'd255}, {8'd255, 8'd255, 8'd255});
    send_pixel({8'd255, 8'd255, 8'd255}, {8'd0, 8'd0, 8'd0});
    send_pixel({8'd0, 8'd0, 8'd0}, {8'd0, 8'd0, 8'd247});
    send_pixel({8'd0, 8'd0, 8'd0}, {8'd0, 8'd247, 8'd0});
    send_pixel({8'd247, 8'd0, 8'd0}, {8'd0, 8'd0, 8'd0});
    send_pixel({8'd0, 8'd0, 8'd0}, {8'd246, 8'd0, 8'd0});
    send_pixel({8'd9, 8'd4, 8'd1}, {8'd255, 8'd4, 8'd1});
    send_pixel({8'd246, 8'd246, 8'd246}, {8'd0, 8'd0, 8'd0});
    send_pixel({8'd10, 8'd10, 8'd10}, {8'd245, 8'd245, 8'd245});
    send_pixel({8'hAA, 8'hAA, 8'hAA}, {8'h55, 8'h55, 8'h55});
    send_pixel({8'h55, 8'h55, 8'h55}, {8'hAA, 8'hAA, 8'hAA});
    send_pixel({8'd128, 8'd64, 8'd32}, {8'd128, 8'd64, 8'd32});
    send_pixel({8'd3, 8'd2, 8'd1}, {8'd3, 8'd2, 8'd255});
    send_pixel({8'd200, 8'd10, 8'd10}, {8'd100, 8'd10, 8'd10});

    for (p = 0; p < NumPhases; p++) begin
      write_cutoff(cutoff_plan[p]);
      set_idle_mode(idle_mode_e'(p % 4));
      for (n = 0; n < ItemsPerPhase; n++) begin
        send_random_pixel();
      end
    end

    drain_pixels();
    set_idle_mode(NoIdle);
    $display("Summary: %0d pixels sent under %0d cutoff settings and four handshake patterns",
             sent, NumPhases + 1);
    $display("Summary: %0d results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
